// ----- sv/qva_pkg.sv -----
// Shared types and constants for the vertical acceleration pipeline.
`default_nettype none

package qva_pkg;

    localparam int GRAV_W = 36;  // gravity component, Q30
    localparam int DIFF_W = 47;  // accel minus gravity, Q30
    localparam int PROD_W = 83;  // one Q60 product
    localparam int DOT_W  = 85;  // Q60 dot product
    localparam int D16_W  = 41;  // dot product, Q16
    localparam int MUL_W  = 62;  // scaled dot product, Q32
    localparam int SHR_W  = 46;  // scaled dot product, Q16

    localparam logic [3:0] ACC_SHIFT_RST = 4'd14;
    localparam logic [4:0] Q30_BITS      = 5'd30;
    localparam logic signed [GRAV_W-1:0] GRAV_ONE = 36'sd1073741824;
    localparam logic signed [20:0]       G_Q16    = 21'sd642689;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_req;

    typedef struct packed {
        logic signed [31:0] vertical_accel;
        logic               saturated;
    } t_rsp;

    typedef struct packed {
        logic signed [GRAV_W-1:0] grav_x;
        logic signed [GRAV_W-1:0] grav_y;
        logic signed [GRAV_W-1:0] grav_z;
        logic signed [15:0]       accel_x;
        logic signed [15:0]       accel_y;
        logic signed [15:0]       accel_z;
    } t_grav;

endpackage

`default_nettype wire

// ----- sv/quaternion_vertical_acceleration.sv -----
// Top level: gravity-removed vertical acceleration from quaternion and accel sample.
//
//  channel | direction | handshake                  | payload
//  in      | request   | i_in_valid / o_in_ready    | i_in_req  (t_req)
//  out     | response  | o_out_valid / i_out_ready  | o_out_rsp (t_rsp)
//  cfg     | write     | i_cfg_we                   | i_cfg_wdata (accel_scale_shift)
//
// Eight register stages; one request per cycle sustained while the output is not stalled.
// The six 32x32 quaternion multiplies and the split 36x47 dot-product
// partial products set the stage count.
// Each stage holds under its own stall, so bubbles are absorbed.
// Reset clears all valid bits and loads accel_scale_shift with 14.
`default_nettype none

module quaternion_vertical_acceleration import qva_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_req       i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_rsp       o_out_rsp
);

    logic [3:0] r_shift;
    logic       g_valid, g_ready, d_valid, d_ready;
    t_grav      g_data;
    logic signed [D16_W-1:0] d_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= ACC_SHIFT_RST;
        end else if (i_cfg_we) begin
            r_shift <= i_cfg_wdata;
        end
    end

    qva_grav u_grav (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (i_in_req),
        .o_valid (g_valid),
        .i_ready (g_ready),
        .o_grav  (g_data)
    );

    qva_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_shift),
        .i_valid (g_valid),
        .o_ready (g_ready),
        .i_grav  (g_data),
        .o_valid (d_valid),
        .i_ready (d_ready),
        .o_d16   (d_data)
    );

    qva_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .o_ready (d_ready),
        .i_d16   (d_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

// ----- sv/qva_grav.sv -----
// Quaternion products and gravity direction, two pipeline stages.
`default_nettype none

module qva_grav import qva_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_req  i_req,
    output logic  o_valid,
    input  logic  i_ready,
    output t_grav o_grav
);

    logic en1, en2;
    logic r_v1, r_v2;
    logic signed [31:0] qw, qx, qy, qz;
    logic signed [63:0] n_xz, n_wy, n_yz, n_wx, n_ww, n_zz;
    logic signed [63:0] r_xz, r_wy, r_yz, r_wx, r_ww, r_zz;
    logic signed [15:0] r_ax, r_ay, r_az;
    logic signed [64:0] sum_x, sum_y, sum_z;
    logic signed [GRAV_W-1:0] gz_raw;
    t_grav n_g, r_g;

    assign en2 = !r_v2 || i_ready;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_grav  = r_g;

    assign qw = i_req.quat_w;
    assign qx = i_req.quat_x;
    assign qy = i_req.quat_y;
    assign qz = i_req.quat_z;

    always_comb begin
        n_xz = qx * qz;
        n_wy = qw * qy;
        n_yz = qy * qz;
        n_wx = qw * qx;
        n_ww = qw * qw;
        n_zz = qz * qz;
    end

    // floor((a +- b) / 2^29), exact in 65 bits
    always_comb begin
        sum_x  = 65'(r_xz) - 65'(r_wy);
        sum_y  = 65'(r_yz) + 65'(r_wx);
        sum_z  = 65'(r_ww) + 65'(r_zz);
        gz_raw = sum_z[64:29];
        n_g.grav_x  = sum_x[64:29];
        n_g.grav_y  = sum_y[64:29];
        n_g.grav_z  = gz_raw - GRAV_ONE;
        n_g.accel_x = r_ax;
        n_g.accel_y = r_ay;
        n_g.accel_z = r_az;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_xz <= n_xz;
            r_wy <= n_wy;
            r_yz <= n_yz;
            r_wx <= n_wx;
            r_ww <= n_ww;
            r_zz <= n_zz;
            r_ax <= i_req.accel_x;
            r_ay <= i_req.accel_y;
            r_az <= i_req.accel_z;
        end
        if (en2) begin
            r_g <= n_g;
        end
    end

endmodule

`default_nettype wire

// ----- sv/qva_dot.sv -----
// Gravity removal and Q60 dot product in split partial products, four stages.
`default_nettype none

module qva_dot import qva_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [3:0]              i_shift,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_grav                   i_grav,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [D16_W-1:0] o_d16
);

    logic en3, en4, en5, en6;
    logic r_v3, r_v4, r_v5, r_v6;
    logic [4:0] up;

    logic signed [GRAV_W-1:0] gv [3];
    logic signed [15:0]       av [3];
    logic signed [DIFF_W-1:0] acc [3];
    logic signed [GRAV_W-1:0] r_g [3];
    logic signed [DIFF_W-1:0] r_d [3];

    logic signed [43:0] n_ll [3];
    logic signed [41:0] n_lh [3];
    logic signed [42:0] n_hl [3];
    logic signed [40:0] n_hh [3];
    logic signed [43:0] r_ll [3];
    logic signed [41:0] r_lh [3];
    logic signed [42:0] r_hl [3];
    logic signed [40:0] r_hh [3];

    logic signed [PROD_W-1:0] n_p [3];
    logic signed [PROD_W-1:0] r_p [3];
    logic signed [DOT_W-1:0]  dot;
    logic signed [D16_W-1:0]  r_d16;

    assign en6 = !r_v6 || i_ready;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign o_ready = en3;
    assign o_valid = r_v6;
    assign o_d16   = r_d16;

    assign up = Q30_BITS - {1'b0, i_shift};

    assign gv[0] = i_grav.grav_x;
    assign gv[1] = i_grav.grav_y;
    assign gv[2] = i_grav.grav_z;
    assign av[0] = i_grav.accel_x;
    assign av[1] = i_grav.accel_y;
    assign av[2] = i_grav.accel_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = DIFF_W'(av[i]) <<< up;
        end
    end

    // g = {hi18 signed, lo18}, d = {hi23 signed, lo24}
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ll[i] = $signed({1'b0, r_g[i][17:0]}) * $signed({1'b0, r_d[i][23:0]});
            n_lh[i] = $signed({1'b0, r_g[i][17:0]}) * $signed(r_d[i][46:24]);
            n_hl[i] = $signed(r_g[i][35:18]) * $signed({1'b0, r_d[i][23:0]});
            n_hh[i] = $signed(r_g[i][35:18]) * $signed(r_d[i][46:24]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p[i] = (PROD_W'(r_hh[i]) <<< 42) + (PROD_W'(r_lh[i]) <<< 24)
                   + (PROD_W'(r_hl[i]) <<< 18) + PROD_W'(r_ll[i]);
        end
        dot = DOT_W'(r_p[0]) + DOT_W'(r_p[1]) + DOT_W'(r_p[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= i_valid;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
            if (en6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (en3) begin
                r_g[i] <= gv[i];
                r_d[i] <= acc[i] - DIFF_W'(gv[i]);
            end
            if (en4) begin
                r_ll[i] <= n_ll[i];
                r_lh[i] <= n_lh[i];
                r_hl[i] <= n_hl[i];
                r_hh[i] <= n_hh[i];
            end
            if (en5) begin
                r_p[i] <= n_p[i];
            end
        end
        if (en6) begin
            r_d16 <= dot[DOT_W-1:44];
        end
    end

endmodule

`default_nettype wire

// ----- sv/qva_scale.sv -----
// Scale to m/s^2, saturate, output register.
`default_nettype none

module qva_scale import qva_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [D16_W-1:0] i_d16,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_rsp                    o_rsp
);

    logic en7, en8;
    logic r_v7, r_v8;
    logic signed [MUL_W-1:0] n_m, r_m;
    logic signed [SHR_W-1:0] shr;
    logic fits;
    t_rsp n_rsp, r_rsp;

    assign en8 = !r_v8 || i_ready;
    assign en7 = !r_v7 || en8;
    assign o_ready = en7;
    assign o_valid = r_v8;
    assign o_rsp   = r_rsp;

    assign n_m = i_d16 * G_Q16;

    always_comb begin
        shr  = r_m[MUL_W-1:16];
        fits = (shr[SHR_W-1:31] == '0) || (shr[SHR_W-1:31] == '1);
        if (fits) begin
            n_rsp.vertical_accel = shr[31:0];
            n_rsp.saturated      = 1'b0;
        end else begin
            n_rsp.vertical_accel = shr[SHR_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            n_rsp.saturated      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            if (en7) begin
                r_v7 <= i_valid;
            end
            if (en8) begin
                r_v8 <= r_v7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r_m <= n_m;
        end
        if (en8) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

`default_nettype wire

// ----- sv/qva_checker.sv -----
// Port-level checks for the vertical acceleration block, bound to the top level.
`default_nettype none

module qva_checker import qva_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_rsp       o_out_rsp
);

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled response changed");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.saturated |->
            (o_out_rsp.vertical_accel == 32'sh7fff_ffff ||
             o_out_rsp.vertical_accel == 32'sh8000_0000))
        else $error("saturated flag without clipped value");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused with empty output");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_valid ##1 !i_in_valid ##1 !i_in_valid ##1 !i_in_valid
        ##1 !i_in_valid ##1 !i_in_valid ##1 !i_in_valid ##1 !i_in_valid
        ##1 !o_out_valid |=> !o_out_valid)
        else $error("response without request");

endmodule

bind quaternion_vertical_acceleration qva_checker u_qva_checker (.*);

`default_nettype wire
